[hw/rtl/dts_pkg.sv]
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, widths and codes for the delayed task scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int HANDLE_W = 16;
  localparam int ID_W     = 32;
  localparam int DELAY_W  = 32;
  localparam int NOW_W    = 48;
  localparam int DUE_W    = 49;

  typedef enum logic [1:0] {
    FUNC_POST       = 2'd0,
    FUNC_POST_DELAY = 2'd1,
    FUNC_CANCEL     = 2'd2,
    FUNC_POP        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_IDLE      = 2'd2,
    ST_NO_CANCEL = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } ready_ent_t;

  typedef struct packed {
    logic [DUE_W-1:0]    due;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } timed_ent_t;

  function automatic logic id_before(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
    logic [ID_W-1:0] d;
    d = a - b;
    return d[ID_W-1];
  endfunction

endpackage

[hw/rtl/dts_ram.sv]
// ----------------------------------------------------------------------------
// dts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/delayed_task_scheduler.sv]
// ----------------------------------------------------------------------------
// delayed_task_scheduler
// Post and pop end in S_FIN; pop reads the heads in S_POP first. Delayed post
// runs the one-entry-per-cycle insertion walk of the timed RAM when it holds
// entries. Cancel walks the ready RAM, then the timed RAM, one entry per cycle per RAM.
// One transaction in flight; a finished result waits in the output register.
// Reset clears counts, pointers and the sequence counter.
// ----------------------------------------------------------------------------
module delayed_task_scheduler
  import dts_pkg::*;
#(
  parameter int READY_DEPTH = 16,
  parameter int TIMED_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [HANDLE_W-1:0] in_task_handle,
  input  logic [DELAY_W-1:0]  in_delay_us,
  input  logic [NOW_W-1:0]    in_now_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_run_handle,
  output logic                out_from_delayed
);

  localparam int RAW = $clog2(READY_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int TAW = $clog2(TIMED_DEPTH);
  localparam int TCW = $clog2(TIMED_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_TI_CHK   = 8'b0000_0010,
    S_TI_PUT   = 8'b0000_0100,
    S_RC_CHK   = 8'b0000_1000,
    S_TC_START = 8'b0001_0000,
    S_TC_CHK   = 8'b0010_0000,
    S_POP      = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RAW-1:0]      rhead_r, rhead_nxt;
  logic [RCW-1:0]      rcnt_r, rcnt_nxt;
  logic [TAW-1:0]      thead_r, thead_nxt;
  logic [TCW-1:0]      tcnt_r, tcnt_nxt;
  logic [ID_W-1:0]     seq_r, seq_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [DUE_W-1:0]    due_r, due_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [NOW_W-1:0]    now_r, now_nxt;
  logic [TAW-1:0]      pos_r, pos_nxt;
  logic [RAW-1:0]      ri_r, ri_nxt, rk_r, rk_nxt;
  logic [TAW-1:0]      ti_r, ti_nxt, tk_r, tk_nxt;
  logic                hit_r, hit_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                res_from_r, res_from_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_from_r, out_from_nxt;

  logic                r_we, t_we;
  logic [RAW-1:0]      r_waddr, r_raddr;
  logic [TAW-1:0]      t_waddr, t_raddr;
  ready_ent_t          r_wdata, r_rdata;
  timed_ent_t          t_wdata, t_rdata, t_new;

  logic                accept, t_due_ok, take_ready, out_free;
  logic [ID_W-1:0]     seq_inc;

  dts_ram #(.WIDTH($bits(ready_ent_t)), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  dts_ram #(.WIDTH($bits(timed_ent_t)), .DEPTH(TIMED_DEPTH)) u_timed_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  function automatic logic [RAW-1:0] rphys(input logic [RAW-1:0] off);
    logic [RAW:0] s;
    s = {1'b0, rhead_r} + {1'b0, off};
    if (s >= (RAW+1)'(READY_DEPTH)) begin
      s = s - (RAW+1)'(READY_DEPTH);
    end
    return s[RAW-1:0];
  endfunction

  function automatic logic [TAW-1:0] tphys(input logic [TAW-1:0] off);
    logic [TAW:0] s;
    s = {1'b0, thead_r} + {1'b0, off};
    if (s >= (TAW+1)'(TIMED_DEPTH)) begin
      s = s - (TAW+1)'(TIMED_DEPTH);
    end
    return s[TAW-1:0];
  endfunction

  assign in_stall         = (state_r != S_IDLE);
  assign accept           = in_valid && (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_run_handle   = out_handle_r;
  assign out_from_delayed = out_from_r;
  assign out_free         = !out_valid_r || !out_stall;
  assign seq_inc          = seq_r + ID_W'(1);
  assign t_new            = '{due: due_r, id: id_r, handle: handle_r};

  assign t_due_ok   = (tcnt_r != '0) && ({1'b0, now_r} >= t_rdata.due);
  assign take_ready = (rcnt_r != '0) && (!t_due_ok || id_before(r_rdata.id, t_rdata.id));

  always_comb begin
    state_nxt      = state_r;
    rhead_nxt      = rhead_r;
    rcnt_nxt       = rcnt_r;
    thead_nxt      = thead_r;
    tcnt_nxt       = tcnt_r;
    seq_nxt        = seq_r;
    handle_nxt     = handle_r;
    due_nxt        = due_r;
    id_nxt         = id_r;
    now_nxt        = now_r;
    pos_nxt        = pos_r;
    ri_nxt         = ri_r;
    rk_nxt         = rk_r;
    ti_nxt         = ti_r;
    tk_nxt         = tk_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_from_nxt   = res_from_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_from_nxt   = out_from_r;
    r_we           = 1'b0;
    r_waddr        = rphys(rcnt_r[RAW-1:0]);
    r_wdata        = '{id: seq_inc, handle: in_task_handle};
    r_raddr        = rphys('0);
    t_we           = 1'b0;
    t_waddr        = tphys(pos_r);
    t_wdata        = t_new;
    t_raddr        = tphys('0);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = '0;
          res_from_nxt   = 1'b0;
          handle_nxt     = in_task_handle;
          now_nxt        = in_now_us;
          unique case (func_t'(in_func))
            FUNC_POST: begin
              seq_nxt   = seq_inc;
              state_nxt = S_FIN;
              if (rcnt_r == RCW'(READY_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                r_we     = 1'b1;
                rcnt_nxt = rcnt_r + RCW'(1);
              end
            end
            FUNC_POST_DELAY: begin
              seq_nxt = seq_inc;
              id_nxt  = seq_inc;
              due_nxt = {1'b0, in_now_us} + DUE_W'(in_delay_us);
              if (tcnt_r == TCW'(TIMED_DEPTH)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_FIN;
              end else if (tcnt_r == '0) begin
                t_we      = 1'b1;
                t_waddr   = tphys('0);
                t_wdata   = '{due: {1'b0, in_now_us} + DUE_W'(in_delay_us),
                              id: seq_inc, handle: in_task_handle};
                tcnt_nxt  = TCW'(1);
                state_nxt = S_FIN;
              end else begin
                pos_nxt   = tcnt_r[TAW-1:0];
                t_raddr   = tphys(tcnt_r[TAW-1:0] - TAW'(1));
                state_nxt = S_TI_CHK;
              end
            end
            FUNC_CANCEL: begin
              hit_nxt = 1'b0;
              ri_nxt  = '0;
              rk_nxt  = '0;
              if (rcnt_r != '0) begin
                state_nxt = S_RC_CHK;
              end else begin
                state_nxt = S_TC_START;
              end
            end
            FUNC_POP: begin
              state_nxt = S_POP;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_TI_CHK: begin
        if (t_rdata.due > due_r) begin
          t_we    = 1'b1;
          t_wdata = t_rdata;
          pos_nxt = pos_r - TAW'(1);
          if (pos_r == TAW'(1)) begin
            state_nxt = S_TI_PUT;
          end else begin
            t_raddr = tphys(pos_r - TAW'(2));
          end
        end else begin
          t_we      = 1'b1;
          tcnt_nxt  = tcnt_r + TCW'(1);
          state_nxt = S_FIN;
        end
      end
      S_TI_PUT: begin
        t_we      = 1'b1;
        tcnt_nxt  = tcnt_r + TCW'(1);
        state_nxt = S_FIN;
      end
      S_RC_CHK: begin
        if (r_rdata.handle == handle_r) begin
          hit_nxt = 1'b1;
        end else begin
          r_we    = 1'b1;
          r_waddr = rphys(rk_r);
          r_wdata = r_rdata;
          rk_nxt  = rk_r + RAW'(1);
        end
        if ((RCW'(ri_r) + RCW'(1)) < rcnt_r) begin
          ri_nxt  = ri_r + RAW'(1);
          r_raddr = rphys(ri_r + RAW'(1));
        end else begin
          rcnt_nxt  = RCW'(rk_r) + RCW'(r_rdata.handle != handle_r);
          state_nxt = S_TC_START;
        end
      end
      S_TC_START: begin
        ti_nxt = '0;
        tk_nxt = '0;
        if (tcnt_r != '0) begin
          state_nxt = S_TC_CHK;
        end else begin
          res_status_nxt = hit_r ? ST_OK : ST_NO_CANCEL;
          state_nxt      = S_FIN;
        end
      end
      S_TC_CHK: begin
        if (t_rdata.handle == handle_r) begin
          hit_nxt = 1'b1;
        end else begin
          t_we    = 1'b1;
          t_waddr = tphys(tk_r);
          t_wdata = t_rdata;
          tk_nxt  = tk_r + TAW'(1);
        end
        if ((TCW'(ti_r) + TCW'(1)) < tcnt_r) begin
          ti_nxt  = ti_r + TAW'(1);
          t_raddr = tphys(ti_r + TAW'(1));
        end else begin
          tcnt_nxt  = TCW'(tk_r) + TCW'(t_rdata.handle != handle_r);
          res_status_nxt =
            (hit_r || (t_rdata.handle == handle_r)) ? ST_OK : ST_NO_CANCEL;
          state_nxt = S_FIN;
        end
      end
      S_POP: begin
        state_nxt = S_FIN;
        if (take_ready) begin
          res_handle_nxt = r_rdata.handle;
          rhead_nxt      = rphys(RAW'(1));
          rcnt_nxt       = rcnt_r - RCW'(1);
        end else if (t_due_ok) begin
          res_handle_nxt = t_rdata.handle;
          res_from_nxt   = 1'b1;
          thead_nxt      = tphys(TAW'(1));
          tcnt_nxt       = tcnt_r - TCW'(1);
        end else begin
          res_status_nxt = ST_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_from_nxt   = res_from_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rhead_r     <= '0;
      rcnt_r      <= '0;
      thead_r     <= '0;
      tcnt_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rhead_r     <= rhead_nxt;
      rcnt_r      <= rcnt_nxt;
      thead_r     <= thead_nxt;
      tcnt_r      <= tcnt_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r     <= handle_nxt;
    due_r        <= due_nxt;
    id_r         <= id_nxt;
    now_r        <= now_nxt;
    pos_r        <= pos_nxt;
    ri_r         <= ri_nxt;
    rk_r         <= rk_nxt;
    ti_r         <= ti_nxt;
    tk_r         <= tk_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_from_r   <= res_from_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_from_r   <= out_from_nxt;
  end

endmodule
